[src/ucb_move_selector_defines.svh]
// Assertion macros shared by the move selector RTL.
`ifndef UCB_MOVE_SELECTOR_DEFINES_SVH
`define UCB_MOVE_SELECTOR_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define UCB_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("move selector assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define UCB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("move selector assertion failed");

`endif

[src/ucb_pkg.sv]
// Types, constants and the log2 fraction table of the UCB move selector.
`timescale 1ns / 1ps
`default_nettype none
package ucb_pkg;

    localparam int SCORE_FRAC_BITS = 16;
    localparam int LN2_Q16         = 45426;
    localparam int DEN_W           = 54;
    localparam int ACC_W           = 48;
    localparam int ROOT_W          = 24;

    // Register word indexes on the configuration port.
    localparam logic REG_EXPLORE_WEIGHT = 1'b0;
    localparam logic [15:0] EXPLORE_WEIGHT_RESET = 16'd256;

    typedef struct packed {
        logic [26:0]        move_visits;
        logic signed [47:0] return_sum;
        logic [26:0]        state_visits;
        logic               last_move;
        logic [15:0]        tie_random;
    } ucb_in_t;

    typedef struct packed {
        logic [4:0]         selected_move;
        logic [4:0]         tie_count;
        logic signed [31:0] best_score;
    } ucb_out_t;

    typedef logic [15:0] log2_tab_t [64];

    // floor(65536*log2(1+m/64)) by sixteen steps of bit-by-bit squaring.
    function automatic log2_tab_t build_log2_tab();
        log2_tab_t   t;
        logic [63:0] x;
        logic [15:0] r;
        int          m;
        int          k;
        for (m = 0; m < 64; m++) begin
            x = 64'(64 + m) << 24;
            r = '0;
            for (k = 15; k >= 0; k--) begin
                x = (x * x) >> 30;
                if (x >= (64'd2 << 30)) begin
                    x = x >> 1;
                    r[k] = 1'b1;
                end
            end
            t[m] = r;
        end
        return t;
    endfunction

    localparam log2_tab_t LOG2_TAB = build_log2_tab();

endpackage
`default_nettype wire

[src/ucb_move_selector.sv]
// Top level of the UCB move selector: sequencer, shared datapath and score store.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one request per move of a game state, in move order, and
// scores each move as mean/(n+1) + C*sqrt(ln(N+1)/(n+1)) in signed Q16.16,
// where n is the move's visit count and N the state's visit count taken from
// the first request of the state. The request marked last_move closes the
// state and yields one result: the index of the best move, with ties broken by
// tie_random in index order, the number of tied moves and the best score.
// Other requests yield no result. Requests past MAX_MOVES are not scored and
// are taken without a busy cycle, but a last mark on one still closes the
// state. The divisions and the square root run through one shared
// subtract-and-shift unit under a small sequencer, one result bit per cycle:
// a 48-step division for the mean term, a second 48-step division for
// ln(N+1)/(n+1) and a 24-step square root, plus the normalization of N+1
// for the logarithm and multiply and update steps. A scored move keeps
// s_ready low until its score is stored; the mean division is skipped when
// its visit count is zero, and the length of the normalization is set by the
// position of the leading one of N+1. On a last request the block then makes
// the tie pick, walks the stored scores until it reaches the chosen one, and
// loads the result once the output register is free. A finished result waits
// in the output register while the next request is taken. The exploration
// weight is to be written through the APB port at byte address 0 while the
// block is idle; the block itself does not enforce this.
module ucb_move_selector
    import ucb_pkg::*;
#(
    parameter int MAX_MOVES = 31
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire ucb_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ucb_out_t      m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

`include "ucb_move_selector_defines.svh"

    localparam int AW = $clog2(MAX_MOVES);
    localparam int CW = $clog2(MAX_MOVES + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_DIV1 = 4'd2;
    localparam logic [3:0] S_T1   = 4'd3;
    localparam logic [3:0] S_NORM = 4'd4;
    localparam logic [3:0] S_LN   = 4'd5;
    localparam logic [3:0] S_DIV2 = 4'd6;
    localparam logic [3:0] S_SQRT = 4'd7;
    localparam logic [3:0] S_TERM = 4'd8;
    localparam logic [3:0] S_SUM  = 4'd9;
    localparam logic [3:0] S_UPD  = 4'd10;
    localparam logic [3:0] S_KMUL = 4'd11;
    localparam logic [3:0] S_RD   = 4'd12;
    localparam logic [3:0] S_CMP  = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    // Control and configuration registers.
    logic [3:0]         state_reg, state_next;
    logic [15:0]        weight_reg;
    logic [CW-1:0]      mv_cnt_reg, mv_cnt_next;
    logic [4:0]         tie_reg, tie_next;
    logic signed [31:0] best_reg, best_next;
    logic [26:0]        sv_reg, sv_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;

    // Payload registers.
    logic [26:0]        n_reg, n_next;
    logic signed [47:0] acc_reg, acc_next;
    logic               last_reg, last_next;
    logic [15:0]        rnd_reg, rnd_next;
    logic [DEN_W-1:0]   divisor_reg, divisor_next;
    logic [DEN_W:0]     rem_reg, rem_next;
    logic [ACC_W-1:0]   quo_reg, quo_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic signed [48:0] term1_reg, term1_next;
    logic [27:0]        nrm_reg, nrm_next;
    logic [4:0]         sh_reg, sh_next;
    logic [26:0]        term2_reg, term2_next;
    logic signed [31:0] score_reg, score_next;
    logic [4:0]         k_reg, k_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [4:0]         sel_reg, sel_next;
    ucb_out_t           m_data_reg, m_data_next;

    // Shared subtract unit.
    logic [DEN_W:0]     sub_a, sub_b;
    logic [DEN_W+1:0]   sub_d;
    logic               sub_borrow;

    logic [DEN_W-1:0]   den_prod;
    logic [20:0]        lg;
    logic [36:0]        ln_prod;
    logic [4:0]         lg_p;
    logic [34:0]        t2_prod;
    logic signed [49:0] sum_full;
    logic [20:0]        k_prod;
    logic [26:0]        sv_eff;
    logic               req_scored;

    logic               ram_we;
    logic [31:0]        ram_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EXPLORE_WEIGHT) ? {16'h0, weight_reg} : 32'h0;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        if (state_reg == S_SQRT) begin
            sub_a = {rem_reg[DEN_W-2:0], quo_reg[ACC_W-1 -: 2]};
            sub_b = {{(DEN_W - ROOT_W - 1){1'b0}}, root_reg, 2'b01};
        end else begin
            sub_a = {rem_reg[DEN_W-1:0], quo_reg[ACC_W-1]};
            sub_b = {1'b0, divisor_reg};
        end
        sub_d      = {1'b0, sub_a} - {1'b0, sub_b};
        sub_borrow = sub_d[DEN_W+1];
    end

    assign den_prod = {27'h0, n_reg} * {26'h0, {1'b0, n_reg} + 28'd1};
    assign lg_p     = 5'd27 - sh_reg;
    assign lg       = {lg_p, 16'h0} | {5'h0, LOG2_TAB[nrm_reg[26:21]]};
    assign ln_prod  = {16'h0, lg} * {21'h0, 16'(LN2_Q16)};
    assign t2_prod  = {19'h0, weight_reg} * {16'h0, root_reg[ROOT_W-1:5]};
    assign sum_full = {term1_reg[48], term1_reg} + $signed({23'h0, term2_reg});
    assign k_prod   = {5'h0, rnd_reg} * {16'h0, tie_reg};
    assign sv_eff   = (mv_cnt_reg == '0) ? s_data.state_visits : sv_reg;
    assign req_scored = s_valid && s_ready && (mv_cnt_reg < CW'(MAX_MOVES));

    always_comb begin
        state_next   = state_reg;
        mv_cnt_next  = mv_cnt_reg;
        tie_next     = tie_reg;
        best_next    = best_reg;
        sv_next      = sv_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        n_next       = n_reg;
        acc_next     = acc_reg;
        last_next    = last_reg;
        rnd_next     = rnd_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        root_next    = root_reg;
        term1_next   = term1_reg;
        nrm_next     = nrm_reg;
        sh_next      = sh_reg;
        term2_next   = term2_reg;
        score_next   = score_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        sel_next     = sel_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    n_next    = s_data.move_visits;
                    acc_next  = s_data.return_sum;
                    last_next = s_data.last_move;
                    rnd_next  = s_data.tie_random;
                    if (mv_cnt_reg < CW'(MAX_MOVES)) begin
                        sv_next    = sv_eff;
                        nrm_next   = {1'b0, sv_eff} + 28'd1;
                        sh_next    = '0;
                        state_next = S_MUL;
                    end else if (s_data.last_move) begin
                        state_next = S_KMUL;
                    end
                end
            end
            S_MUL: begin
                divisor_next = den_prod;
                quo_next     = acc_reg[47] ? 48'(-acc_reg) : 48'(acc_reg);
                rem_next     = '0;
                cnt_next     = 6'(ACC_W);
                if (n_reg == '0) begin
                    term1_next = '0;
                    state_next = S_NORM;
                end else begin
                    state_next = S_DIV1;
                end
            end
            S_DIV1, S_DIV2: begin
                rem_next = sub_borrow ? sub_a : sub_d[DEN_W:0];
                quo_next = {quo_reg[ACC_W-2:0], ~sub_borrow};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = (state_reg == S_DIV1) ? S_T1 : S_SQRT;
                    if (state_reg == S_DIV2) begin
                        // v = ln(N+1)/(n+1) fits in 21 bits; the root works on
                        // v*2^26 from a cleared remainder and root.
                        quo_next  = {quo_reg[20:0], ~sub_borrow, 26'h0};
                        rem_next  = '0;
                        root_next = '0;
                        cnt_next  = 6'(ROOT_W);
                    end
                end
            end
            S_T1: begin
                term1_next = acc_reg[47] ? -$signed({1'b0, quo_reg})
                                         : $signed({1'b0, quo_reg});
                state_next = S_NORM;
            end
            S_NORM: begin
                if (nrm_reg[27]) begin
                    state_next = S_LN;
                end else begin
                    nrm_next = {nrm_reg[26:0], 1'b0};
                    sh_next  = sh_reg + 5'd1;
                end
            end
            S_LN: begin
                // ln(N+1) in Q16 is the dividend of the second division.
                quo_next     = {27'h0, ln_prod[36:16]};
                divisor_next = {26'h0, {1'b0, n_reg} + 28'd1};
                rem_next     = '0;
                cnt_next     = 6'(ACC_W);
                state_next   = S_DIV2;
            end
            S_SQRT: begin
                rem_next  = sub_borrow ? sub_a : sub_d[DEN_W:0];
                root_next = {root_reg[ROOT_W-2:0], ~sub_borrow};
                quo_next  = {quo_reg[ACC_W-3:0], 2'b00};
                cnt_next  = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = S_TERM;
                end
            end
            S_TERM: begin
                term2_next = t2_prod[34:8];
                state_next = S_SUM;
            end
            S_SUM: begin
                if (sum_full[49:31] == {19{sum_full[49]}}) begin
                    score_next = sum_full[31:0];
                end else if (sum_full[49]) begin
                    score_next = 32'sh8000_0000;
                end else begin
                    score_next = 32'sh7fff_ffff;
                end
                state_next = S_UPD;
            end
            S_UPD: begin
                ram_we = 1'b1;
                if (mv_cnt_reg == '0 || score_reg > best_reg) begin
                    best_next = score_reg;
                    tie_next  = 5'd1;
                end else if (score_reg == best_reg) begin
                    tie_next = tie_reg + 5'd1;
                end
                mv_cnt_next = mv_cnt_reg + CW'(1);
                state_next  = last_reg ? S_KMUL : S_IDLE;
            end
            S_KMUL: begin
                k_next     = k_prod[20:16];
                idx_next   = '0;
                sel_next   = '0;
                state_next = S_RD;
            end
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                state_next = S_RD;
                if ($signed(ram_rdata) == best_reg) begin
                    if (k_reg == '0) begin
                        sel_next   = 5'(idx_reg);
                        state_next = S_OUT;
                    end else begin
                        k_next = k_reg - 5'd1;
                    end
                end
                if (CW'(idx_reg) + CW'(1) >= mv_cnt_reg) begin
                    state_next = S_OUT;
                end
                idx_next = idx_reg + AW'(1);
            end
            S_OUT: begin
                // The previous result must leave the output register first.
                if (!m_valid_reg || m_ready) begin
                    m_data_next.selected_move = sel_reg;
                    m_data_next.tie_count     = tie_reg;
                    m_data_next.best_score    = best_reg;
                    m_valid_next = 1'b1;
                    mv_cnt_next  = '0;
                    tie_next     = '0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            weight_reg  <= EXPLORE_WEIGHT_RESET;
            mv_cnt_reg  <= '0;
            tie_reg     <= '0;
            best_reg    <= '0;
            sv_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mv_cnt_reg  <= mv_cnt_next;
            tie_reg     <= tie_next;
            best_reg    <= best_next;
            sv_reg      <= sv_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (psel && penable && pwrite && pready && paddr[2] == REG_EXPLORE_WEIGHT) begin
                weight_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        acc_reg     <= acc_next;
        last_reg    <= last_next;
        rnd_reg     <= rnd_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        root_reg    <= root_next;
        term1_reg   <= term1_next;
        nrm_reg     <= nrm_next;
        sh_reg      <= sh_next;
        term2_reg   <= term2_next;
        score_reg   <= score_next;
        k_reg       <= k_next;
        idx_reg     <= idx_next;
        sel_reg     <= sel_next;
        m_data_reg  <= m_data_next;
    end

    ucb_ram #(
        .WIDTH (32),
        .DEPTH (MAX_MOVES)
    ) u_scores (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (mv_cnt_reg[AW-1:0]),
        .wdata (score_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    `UCB_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, req_scored, !s_ready)
    `UCB_ASSERT_IMPL(a_cnt_bound, aclk, aresetn, 1'b1, mv_cnt_reg <= CW'(MAX_MOVES))
    `UCB_ASSERT_IMPL(a_ties_nonzero, aclk, aresetn, m_valid, m_data.tie_count != 5'd0)
    `UCB_ASSERT_IMPL(a_sel_bound, aclk, aresetn, m_valid, m_data.selected_move < 5'(MAX_MOVES))

endmodule
`default_nettype wire

[src/ucb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ucb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 31
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the UCB move selector: scoreboard, request driver and checks.
`timescale 1ns / 1ps
import ucb_pkg::*;

// Scores the first 31 move requests of each state, tracks the state being
// loaded, and keeps the results that the closing requests are due to produce.
class move_scoreboard;
    bit [15:0]   weight;
    int          errors;
    int          states_closed;
    int unsigned lg_frac [64];
    int          score_of [31];
    int          best;
    int unsigned ties;
    int unsigned moves;
    bit [26:0]   nstate;
    ucb_out_t    due_q [$];

    function new();
        bit [63:0]   x;
        int unsigned r;
        for (int m = 0; m < 64; m++) begin
            x = 64'(64 + m) << 24;
            r = 0;
            for (int k = 15; k >= 0; k--) begin
                x = (x * x) >> 30;
                if (x >= (64'd2 << 30)) begin
                    x = x >> 1;
                    r |= 1 << k;
                end
            end
            lg_frac[m] = r;
        end
        weight = EXPLORE_WEIGHT_RESET;
        errors = 0;
        states_closed = 0;
        moves = 0;
        ties = 0;
        best = 0;
        nstate = '0;
    endfunction

    // Mean term plus weighted exploration term, saturated to 32 bits.
    function int ucb_score(bit [26:0] n, bit [47:0] rs, bit [26:0] ns);
        longint          mean_t, acc, total;
        longint unsigned den, lnv, lg, v, arg, r, t, root, np1;
        int unsigned     p, m;
        acc = {{16{rs[47]}}, rs};
        mean_t = 0;
        if (n != 0) begin
            den = longint'(n) * (longint'(n) + 1);
            mean_t = acc / longint'(den);
        end
        np1 = longint'(ns) + 1;
        p = 0;
        for (int b = 0; b < 32; b++)
            if (np1[b]) p = b;
        if (p >= 6) m = (np1 >> (p - 6)) & 63;
        else m = (np1 << (6 - p)) & 63;
        lg = longint'(p) * 65536 + lg_frac[m];
        lnv = (lg * 45426) >> 16;
        v = lnv / (longint'(n) + 1);
        arg = v << 26;
        r = 0;
        for (int b = 23; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= arg) r = t;
        end
        root = r >> 5;
        total = mean_t + longint'((longint'(weight) * root) >> 8);
        if (total > 64'sd2147483647) total = 64'sd2147483647;
        if (total < -64'sd2147483648) total = -64'sd2147483648;
        return int'(total);
    endfunction

    function void note_request(ucb_in_t req);
        int          s;
        int unsigned k, sel;
        ucb_out_t    res;
        if (moves == 0) nstate = req.state_visits;
        if (moves < 31) begin
            s = ucb_score(req.move_visits, req.return_sum, nstate);
            score_of[moves] = s;
            if (moves == 0 || s > best) begin
                best = s;
                ties = 1;
            end else if (s == best) begin
                ties++;
            end
            moves++;
        end
        if (!req.last_move) return;
        k = (32'(req.tie_random) * ties) >> 16;
        sel = 0;
        for (int i = 0; i < moves; i++) begin
            if (score_of[i] == best) begin
                if (k == 0) begin
                    sel = i;
                    break;
                end
                k--;
            end
        end
        res.selected_move = sel[4:0];
        res.tie_count = ties[4:0];
        res.best_score = best;
        due_q = {due_q, res};
        moves = 0;
        ties = 0;
    endfunction

    function void check_result(ucb_out_t got);
        ucb_out_t want;
        if (due_q.size() == 0) begin
            $error("result with nothing outstanding: %p", got);
            errors++;
            return;
        end
        want = due_q.pop_front();
        states_closed++;
        if (got.selected_move !== want.selected_move) begin
            $error("selected_move expected %0d actual %0d", want.selected_move, got.selected_move);
            errors++;
        end
        if (got.tie_count !== want.tie_count) begin
            $error("tie_count expected %0d actual %0d", want.tie_count, got.tie_count);
            errors++;
        end
        if (got.best_score !== want.best_score) begin
            $error("best_score expected %0d actual %0d", want.best_score, got.best_score);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int STALL_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    ucb_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    ucb_out_t    m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    move_scoreboard sb;
    int          src_idle;
    int          snk_idle;
    int          quiet_cycles;
    int          requests_sent;
    ucb_in_t     prev_req;

    ucb_move_selector u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side: check every accepted result, stall at random, and watch
    // for a run that stops making progress.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((m_valid && m_ready) || (s_valid && s_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
            m_ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    task automatic apb_write(input logic [15:0] w);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_EXPLORE_WEIGHT, 2'b00};
        pwdata <= {16'd0, w};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.weight = w;
    endtask

    task automatic send_request(input ucb_in_t req);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req);
        requests_sent++;
        prev_req = req;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge aclk);
        // A request without a result may still be in the datapath.
        repeat (400) @(posedge aclk);
    endtask

    function automatic ucb_in_t make_request(input bit last);
        ucb_in_t r;
        int      pick;
        pick = $urandom_range(9);
        r.move_visits = (pick < 2) ? 27'd0 : (pick < 7) ? 27'($urandom_range(200))
                                                         : 27'($urandom);
        pick = $urandom_range(9);
        r.return_sum = (pick < 5) ? 48'({$urandom, $urandom})
                                  : 48'(longint'($urandom_range(4000000)) - 2000000);
        r.state_visits = ($urandom_range(1)) ? 27'($urandom) : 27'($urandom_range(5000));
        r.tie_random = 16'($urandom);
        r.last_move = last;
        // Repeat the previous move's statistics now and then to build ties.
        if ($urandom_range(3) == 0) begin
            r.move_visits = prev_req.move_visits;
            r.return_sum = prev_req.return_sum;
        end
        return r;
    endfunction

    task automatic send_state(input int count);
        for (int i = 0; i < count; i++) send_request(make_request(i == count - 1));
    endtask

    task automatic random_phase(input int target);
        int goal;
        int cnt;
        goal = requests_sent + target;
        while (requests_sent < goal) begin
            if ($urandom_range(19) == 0) cnt = $urandom_range(32, 35);
            else if ($urandom_range(9) == 0) cnt = $urandom_range(7, 31);
            else cnt = $urandom_range(1, 6);
            send_state(cnt);
        end
    endtask

    task automatic directed_part();
        ucb_in_t r;
        r = '0;
        r.last_move = 1'b1;
        send_request(r);                           // single move with no visits
        r.move_visits = 27'h7FFFFFF;
        r.return_sum = 48'h7FFF_FFFF_FFFF;
        r.state_visits = 27'h7FFFFFF;
        r.tie_random = 16'hFFFF;
        send_request(r);                           // all fields at their maximum
        r.move_visits = 27'd1;
        r.return_sum = 48'h8000_0000_0000;
        r.state_visits = 27'd0;
        send_request(r);                           // most negative return sum
        r.move_visits = 27'd1;
        r.return_sum = 48'h7FFF_FFFF_FFFF;
        send_request(r);                           // mean term saturates high
        // Three equal moves, picking the last and then the first of the ties.
        for (int pass = 0; pass < 2; pass++) begin
            for (int i = 0; i < 3; i++) begin
                r.move_visits = 27'd0;
                r.return_sum = 48'($urandom);
                r.state_visits = 27'd99;
                r.last_move = (i == 2);
                r.tie_random = pass ? 16'h0000 : 16'hFFFF;
                send_request(r);
            end
        end
        // Distinct moves where the best one is in the middle, unless a large exploration weight favours the first.
        for (int i = 0; i < 4; i++) begin
            r.move_visits = 27'(i + 1);
            r.return_sum = (i == 2) ? 48'd900000 : 48'd1000;
            r.state_visits = (i == 0) ? 27'd1000 : 27'h5555555;
            r.last_move = (i == 3);
            r.tie_random = 16'h8000;
            send_request(r);
        end
        drain();
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        src_idle = 0;
        snk_idle = 0;
        requests_sent = 0;
        prev_req = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_part();
        apb_write(16'hFFFF);
        directed_part();
        apb_write(16'd0);
        directed_part();

        apb_write(16'd256);
        random_phase(460);
        drain();
        apb_write(16'hFFFF);
        src_idle = 53;
        random_phase(460);
        drain();
        apb_write(16'd0);
        src_idle = 0;
        snk_idle = 53;
        random_phase(460);
        drain();
        apb_write(16'($urandom));
        src_idle = 37;
        snk_idle = 37;
        random_phase(460);
        drain();

        $display("Sent %0d move requests, %0d states closed, weights 0 to 65535.",
                 requests_sent, sb.states_closed);
        $display("Idle patterns covered: none, sender, receiver and both.");
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+src
src/ucb_pkg.sv
src/ucb_ram.sv
src/ucb_move_selector.sv
sim/tb.sv
